@@ hw/rtl/bs_pkg.sv @@
package bs_pkg;

  localparam int unsigned DataWidth = 32;

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] sorted_value;
    logic                        final_res;
    logic                        overflow;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/bubble_sorter_top.sv @@
// Sorter for lists of signed 32-bit values.
// Input: drive item_i and raise start; the item is taken at a rising edge with
// start high and busy low. Items go into a row of CAPACITY cells kept in
// ascending order, one item per cycle. Items past CAPACITY are dropped and
// the list is marked as overflowed.
// The item with last set ends the list. From the next cycle busy is high and
// one result per cycle leaves through res_o, marked by res_valid_o, smallest
// first; final_res marks the last one, overflow is the same on all of them.
// A list is loaded and then drained: the edge that takes the last item sets
// drain_q, and the first result then passes from cell 0 through res_q onto
// res_o.
// Drain speed is set by the cell row, which shifts down one place per cycle.
// Results are strobed for one cycle only; the receiver cannot stall them.
// Reset empties the row and clears the overflow mark.
module bubble_sorter_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bs_pkg::in_item_t  item_i,
  output logic              res_valid_o,
  output bs_pkg::out_item_t res_o
);

  logic signed [bs_pkg::DataWidth-1:0] cell_value [CAPACITY];
  logic                                cell_valid [CAPACITY];
  logic                                cell_lt    [CAPACITY];

  logic               drain_q, drain_d;
  logic               dropped_q, dropped_d;
  logic               res_valid_q, res_valid_d;
  bs_pkg::out_item_t  res_q, res_d;
  bs_pkg::cell_ctrl_t ctrl;
  logic               accept;
  logic               full;
  logic               drain_final;

  assign accept      = start && !drain_q;
  assign full        = cell_valid[CAPACITY-1];
  assign drain_final = !cell_valid[1];

  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = drain_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [bs_pkg::DataWidth-1:0] prev_value, next_value;
    logic                                prev_valid, next_valid, prev_lt;

    if (i == 0) begin : g_head
      assign prev_lt    = 1'b0;
      assign prev_value = item_i.value;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_lt    = cell_lt[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    bs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (item_i.value),
      .prev_lt_i    (prev_lt),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .lt_o         (cell_lt[i]),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i])
    );
  end

  always_comb begin
    drain_d     = drain_q;
    dropped_d   = dropped_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (drain_q) begin
      res_valid_d        = 1'b1;
      res_d.sorted_value = cell_value[0];
      res_d.final_res    = drain_final;
      res_d.overflow     = dropped_q;
      if (drain_final) begin
        drain_d   = 1'b0;
        dropped_d = 1'b0;
      end
    end else if (accept) begin
      if (full) begin
        dropped_d = 1'b1;
      end
      if (item_i.last) begin
        drain_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      dropped_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      drain_q     <= drain_d;
      dropped_q   <= dropped_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy        = drain_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ hw/rtl/bs_cell.sv @@
module bs_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bs_pkg::cell_ctrl_t                   ctrl_i,
  input  logic signed [bs_pkg::DataWidth-1:0]  new_value_i,
  input  logic                                 prev_lt_i,
  input  logic signed [bs_pkg::DataWidth-1:0]  prev_value_i,
  input  logic                                 prev_valid_i,
  input  logic signed [bs_pkg::DataWidth-1:0]  next_value_i,
  input  logic                                 next_valid_i,
  output logic                                 lt_o,
  output logic signed [bs_pkg::DataWidth-1:0]  value_o,
  output logic                                 valid_o
);

  logic signed [bs_pkg::DataWidth-1:0] value_q, value_d;
  logic                                valid_q, valid_d;

  assign lt_o = !valid_q || (new_value_i < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.insert && lt_o) begin
      if (prev_lt_i) begin
        value_d = prev_value_i;
        valid_d = prev_valid_i;
      end else begin
        value_d = new_value_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule
